// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; the clock is clk and the
// asynchronous active-low reset is rst_n in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property while out of reset.
`define FVW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FVW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FVW_ASSERT(lbl, prop, msg)
`define FVW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/fvw_pkg.sv -----
// ----------------------------------------------------------------------------
// fvw_pkg
// Types and fixed widths shared by the FIR filter core and its MAC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fvw_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 11;
    localparam int IDX_W    = 10;

    localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_PUSH    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef struct packed {
        logic clear;
        logic rd_valid;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/fvw_mac.sv -----
// ----------------------------------------------------------------------------
// fvw_mac
// Multiply-accumulate unit: registers one coefficient-sample product per
// beat of memory read data and adds it to a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fvw_mac #(
    parameter int ACC_W = 42
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fvw_pkg::mac_ctl_t                     ctl,
    input  logic signed [fvw_pkg::SAMPLE_W-1:0]   coef,
    input  logic signed [fvw_pkg::SAMPLE_W-1:0]   sample,
    output logic signed [ACC_W-1:0]               acc,
    output logic                                  busy
);
    import fvw_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_valid)
        begin
            prod_reg <= coef * sample;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fir_filter_valid_window.sv -----
// ----------------------------------------------------------------------------
// fir_filter_valid_window
// Direct-form FIR filter. Coefficients and sample history sit in two
// synchronous memories; one shared MAC walks the window oldest sample first.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     mode, tap_index, value
//   out      output     out_valid / out_ready   filtered_sample
//   cfg      input      cfg_valid / cfg_ready   cfg_data (tap_count)
//
// A load, a restart, or a push that does not fill the window is handled in
// the idle state. A push that yields a result runs the MAC, which reads one
// tap per cycle from both memories, then drains, scales and saturates.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only a second result stalls until the first is taken.
// Reset clears the pointer, fill count and tap_count (to 1); memories hold.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fir_filter_valid_window #(
    parameter int MAX_TAPS       = 1024,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [fvw_pkg::IDX_W-1:0]            tap_index,
    input  logic signed [fvw_pkg::SAMPLE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fvw_pkg::OUT_W-1:0]     filtered_sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fvw_pkg::CFG_W-1:0]            cfg_data
);
    import fvw_pkg::*;

    localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int SUM_W  = PTR_W + 2;
    localparam logic [ACC_W-1:0] BIAS = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          tap_count_reg;
    logic [PTR_W-1:0]          wptr_reg, wptr_next, wptr_inc;
    logic [FILL_W-1:0]         fill_reg, fill_next, fill_inc;
    logic [FILL_W-1:0]         cnt_reg, cnt_next;
    logic [FILL_W-1:0]         taps_reg, taps_next;
    logic [PTR_W-1:0]          pos_reg, pos_next;
    logic                      rd_vld_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   out_data_reg;
    logic signed [ACC_W-1:0]   scaled_reg;

    logic [SAMPLE_W-1:0]       coef_mem [MAX_TAPS];
    logic [SAMPLE_W-1:0]       hist_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] coef_rd_reg;
    logic signed [SAMPLE_W-1:0] hist_rd_reg;

    logic [31:0]               taps_wide;
    logic [31:0]               idx_wide;
    logic [FILL_W-1:0]         eff_taps;
    logic [SUM_W-1:0]          start_sum;
    logic [PTR_W-1:0]          start_pos;
    logic                      coef_we;
    logic                      hist_we;
    logic                      rd_issue;
    logic                      do_emit;
    mac_ctl_t                  mac_ctl;
    logic signed [ACC_W-1:0]   acc;
    logic                      mac_busy;
    logic signed [ACC_W-1:0]   acc_biased;
    logic [ACC_W-OUT_W:0]      upper;
    logic signed [OUT_W-1:0]   sat_value;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_wide = 32'd1;
        end
        else if (32'(tap_count_reg) > 32'(MAX_TAPS))
        begin
            taps_wide = 32'(MAX_TAPS);
        end
        else
        begin
            taps_wide = 32'(tap_count_reg);
        end
    end

    assign eff_taps  = taps_wide[FILL_W-1:0];
    assign idx_wide  = 32'(tap_index);
    assign wptr_inc  = (wptr_reg == PTR_W'(MAX_TAPS - 1)) ? '0 : wptr_reg + 1'b1;
    assign fill_inc  = (fill_reg == FILL_W'(MAX_TAPS)) ? fill_reg : fill_reg + 1'b1;
    assign start_sum = SUM_W'(wptr_inc) + SUM_W'(MAX_TAPS) - SUM_W'(eff_taps);
    assign start_pos = (start_sum >= SUM_W'(MAX_TAPS)) ?
                       PTR_W'(start_sum - SUM_W'(MAX_TAPS)) : PTR_W'(start_sum);

    assign rd_issue  = (state_reg == ST_MAC) && (cnt_reg != taps_reg);
    assign do_emit   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        wptr_next        = wptr_reg;
        fill_next        = fill_reg;
        cnt_next         = cnt_reg;
        taps_next        = taps_reg;
        pos_next         = pos_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        coef_we          = 1'b0;
        hist_we          = 1'b0;
        mac_ctl.clear    = 1'b0;
        mac_ctl.rd_valid = rd_vld_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(mode))
                        MODE_LOAD:
                        begin
                            coef_we = (idx_wide < 32'(MAX_TAPS));
                        end
                        MODE_PUSH:
                        begin
                            hist_we   = 1'b1;
                            wptr_next = wptr_inc;
                            fill_next = fill_inc;
                            if (fill_inc >= eff_taps)
                            begin
                                state_next    = ST_MAC;
                                cnt_next      = '0;
                                pos_next      = start_pos;
                                taps_next     = eff_taps;
                                mac_ctl.clear = 1'b1;
                            end
                        end
                        MODE_RESTART:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                if (rd_issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    pos_next = (pos_reg == PTR_W'(MAX_TAPS - 1)) ? '0 : pos_reg + 1'b1;
                end
                else if (!rd_vld_reg && !mac_busy)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (do_emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= CFG_W'(1);
            wptr_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            taps_reg      <= '0;
            pos_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            taps_reg      <= taps_next;
            pos_reg       <= pos_next;
            rd_vld_reg    <= rd_issue;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                tap_count_reg <= cfg_data;
            end
        end
    end

    // Coefficient and history memories, registered reads
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[idx_wide[PTR_W-1:0]] <= value;
        end
        if (rd_issue)
        begin
            coef_rd_reg <= coef_mem[cnt_reg[PTR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wptr_reg] <= value;
        end
        if (rd_issue)
        begin
            hist_rd_reg <= hist_mem[pos_reg];
        end
    end

    fvw_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef   (coef_rd_reg),
        .sample (hist_rd_reg),
        .acc    (acc),
        .busy   (mac_busy)
    );

    // Truncate toward zero: bias negative sums before the arithmetic shift
    assign acc_biased = $signed(acc + (acc[ACC_W-1] ? $signed(BIAS) : $signed(ACC_W'(0))));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCALE)
        begin
            scaled_reg <= acc_biased >>> COEF_FRAC_BITS;
        end
        if (do_emit)
        begin
            out_data_reg <= sat_value;
        end
    end

    assign upper = scaled_reg[ACC_W-1:OUT_W-1];

    always_comb
    begin
        if ((upper == '0) || (upper == '1))
        begin
            sat_value = scaled_reg[OUT_W-1:0];
        end
        else if (scaled_reg[ACC_W-1])
        begin
            sat_value = OUT_MIN;
        end
        else
        begin
            sat_value = OUT_MAX;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_data_reg;
    assign cfg_ready       = 1'b1;

    `FVW_ASSERT(a_idle_mac_quiet, (state_reg == ST_IDLE) |-> (!rd_vld_reg && !mac_busy), "MAC pipeline active while accepting items")
    `FVW_ASSERT(a_scale_after_all_taps, (state_reg == ST_SCALE) |-> (cnt_reg == taps_reg), "scale entered before every tap was read")
    `FVW_ASSERT(a_fill_bounded, (fill_reg <= FILL_W'(MAX_TAPS)), "fill count above tap capacity")
    `FVW_ASSERT(a_wptr_bounded, (32'(wptr_reg) < 32'(MAX_TAPS)), "history pointer out of range")
    `FVW_ASSERT(a_emit_loads_output, do_emit |=> out_valid_reg, "emitted result not held in output register")

endmodule

`default_nettype wire

// ----- tb/sv/fir_filter_valid_window_test.sv -----
// ----------------------------------------------------------------------------
// fir_filter_valid_window_test
// Self-checking bench for the direct-form FIR filter. A queue-fed driver
// offers load, push, restart and unused-mode beats with random gaps, and a
// ready generator stalls the output side in bursts and once for a long
// stretch. A predictor in the bench keeps its own coefficient store, sample
// history, pointer and fill count, and queues the filter output for every
// push that completes a window. The monitor checks each output beat against
// the oldest queued value. The run steps through several tap counts: the
// reset value, zero, a long window over preloaded coefficients, and small ones.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_valid_window_test;

    import fvw_pkg::*;

    localparam int          MAX_TAPS       = 1024;
    localparam int          COEF_FRAC_BITS = 15;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam int          PHASES         = 8;
    localparam int          PHASE_BEATS    = 62;
    localparam int          PRELOAD_TAPS   = 40;
    localparam int          LONG_HOLD      = 400;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          DRAIN_CYCLES   = MAX_TAPS + 80;
    localparam int          CYCLE_LIMIT    = 1_000_000;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [IDX_W-1:0]            idx;
        logic signed [SAMPLE_W-1:0]  val;
    } in_beat_t;

    logic                        clk             = 1'b0;
    logic                        rst_n           = 1'b0;
    logic                        in_valid        = 1'b0;
    logic                        in_ready;
    logic [1:0]                  mode            = '0;
    logic [IDX_W-1:0]            tap_index       = '0;
    logic signed [SAMPLE_W-1:0]  value           = '0;
    logic                        out_valid;
    logic                        out_ready       = 1'b0;
    logic signed [OUT_W-1:0]     filtered_sample;
    logic                        cfg_valid       = 1'b0;
    logic                        cfg_ready;
    logic [CFG_W-1:0]            cfg_data        = '0;

    in_beat_t                    beat_q[$];
    logic signed [OUT_W-1:0]     filtered_q[$];

    logic signed [SAMPLE_W-1:0]  coef_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]  history  [MAX_TAPS];
    int unsigned                 wr_ptr      = 0;
    int unsigned                 fill        = 0;
    int unsigned                 tap_setting = 1;

    bit                          idle_on       = 1'b1;
    int                          hold_requests = 0;
    int                          errors        = 0;
    int                          cycle_count   = 0;
    int                          n_push        = 0;
    int                          n_load        = 0;
    int                          n_restart     = 0;
    int                          n_unused      = 0;
    int                          n_checked     = 0;
    int                          n_settings    = 0;

    fir_filter_valid_window #(
        .MAX_TAPS       (MAX_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .tap_index       (tap_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 40)
        begin
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        end
        errors++;
    endtask

    function automatic int unsigned active_taps(input int unsigned setting);
        if (setting == 0)
        begin
            return 1;
        end
        if (setting > MAX_TAPS)
        begin
            return MAX_TAPS;
        end
        return setting;
    endfunction

    function automatic logic signed [OUT_W-1:0] scale_sum(input longint acc);
        longint mag;
        mag = (acc < 0) ? -acc : acc;
        mag = mag >> COEF_FRAC_BITS;
        if (acc < 0)
        begin
            return (mag >= 64'sh8000_0000) ? OUT_MIN : OUT_W'(-mag);
        end
        return (mag > 64'sh7FFF_FFFF) ? OUT_MAX : OUT_W'(mag);
    endfunction

    function automatic void run_filter_item(input in_beat_t b);
        int unsigned taps;
        int unsigned pos;
        longint      acc;
        case (b.mode)
            MODE_LOAD:
            begin
                coef_mem[b.idx] = b.val;
                n_load++;
            end
            MODE_RESTART:
            begin
                fill = 0;
                n_restart++;
            end
            MODE_PUSH:
            begin
                n_push++;
                history[wr_ptr] = b.val;
                wr_ptr = (wr_ptr + 1) % MAX_TAPS;
                if (fill < MAX_TAPS)
                begin
                    fill++;
                end
                taps = active_taps(tap_setting);
                if (fill >= taps)
                begin
                    acc = 0;
                    for (int unsigned j = 0; j < taps; j++)
                    begin
                        pos = (wr_ptr + MAX_TAPS - taps + j) % MAX_TAPS;
                        acc += longint'(coef_mem[j]) * longint'(history[pos]);
                    end
                    filtered_q.push_back(scale_sum(acc));
                end
            end
            default:
            begin
                n_unused++;
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] m, input int unsigned idx,
                              input logic signed [SAMPLE_W-1:0] val);
        in_beat_t b;
        b.mode = m;
        b.idx  = IDX_W'(idx);
        b.val  = val;
        beat_q.push_back(b);
    endtask

    task automatic queue_random(input int count, input int unsigned taps);
        int          useful;
        int unsigned roll;
        int unsigned restart_pct;
        in_beat_t    b;
        useful      = 0;
        restart_pct = (active_taps(taps) > 32) ? 1 : 6;
        while (useful < count)
        begin
            roll  = $urandom_range(0, 99);
            b.idx = IDX_W'($urandom);
            b.val = pick_value();
            if (roll < 15)
            begin
                b.mode = MODE_LOAD;
            end
            else if (roll < 15 + restart_pct)
            begin
                b.mode = MODE_RESTART;
            end
            else if (roll < 20 + restart_pct)
            begin
                b.mode = MODE_UNUSED;
            end
            else
            begin
                b.mode = MODE_PUSH;
            end
            if (b.mode != MODE_UNUSED)
            begin
                useful++;
            end
            beat_q.push_back(b);
        end
    endtask

    task automatic settle();
        while (beat_q.size() != 0 || in_valid || filtered_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_taps(input int unsigned setting);
        settle();
        @(posedge clk);
        cfg_data  <= CFG_W'(setting);
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        tap_setting = setting;
        n_settings++;
        @(negedge clk);
    endtask

    // driver: hold the beat until accepted, then advance or idle
    in_beat_t cur_beat  = '0;
    int       send_gap  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                run_filter_item(cur_beat);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 9) - 1;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    cur_beat  = beat_q.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= cur_beat.mode;
                    tap_index <= cur_beat.idx;
                    value     <= cur_beat.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    int hold_left  = 0;
    int holds_done = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor: a beat seen at the falling edge is taken at the next rising edge
    always @(negedge clk)
    begin
        logic signed [OUT_W-1:0] want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (filtered_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output %0d", filtered_sample));
            end
            else
            begin
                want = filtered_q.pop_front();
                n_checked++;
                if (filtered_sample !== want)
                begin
                    report_mismatch($sformatf("filtered_sample got %0d want %0d",
                                              filtered_sample, want));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_cfg [PHASES];
        phase_cfg = '{PRELOAD_TAPS, 0, 3, 1, $urandom_range(4, 32), 2,
                      $urandom_range(1, 32), 16};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single tap out of reset: rounding toward zero, extremes, restart
        queue_item(MODE_LOAD, 0, 16'sh8000);
        queue_item(MODE_PUSH, 0, 16'sh7FFF);
        queue_item(MODE_PUSH, 0, 16'sh8000);
        queue_item(MODE_PUSH, 0, 16'sh0000);
        queue_item(MODE_PUSH, 0, 16'sh0001);
        queue_item(MODE_LOAD, 0, 16'sh0001);
        queue_item(MODE_PUSH, 0, 16'shFFFF);
        queue_item(MODE_UNUSED, MAX_TAPS - 1, 16'shFFFF);
        queue_item(MODE_RESTART, 0, 16'sh0000);
        queue_item(MODE_PUSH, 0, 16'sh0005);
        queue_item(MODE_LOAD, MAX_TAPS - 1, 16'sh7FFF);
        queue_item(MODE_LOAD, 1, 16'sh4000);

        write_taps(0);
        queue_item(MODE_PUSH, 0, 16'sh7FFF);
        queue_item(MODE_PUSH, 0, 16'sh8000);

        write_taps(2);
        queue_item(MODE_LOAD, 1, 16'sh8000);
        queue_item(MODE_PUSH, 0, 16'sh7FFF);
        queue_item(MODE_PUSH, 0, 16'sh8000);
        queue_item(MODE_PUSH, 0, 16'sh0007);

        // coefficients for the longest window of the phases below
        queue_item(MODE_RESTART, 0, 16'sh0000);
        for (int i = 0; i < PRELOAD_TAPS; i++)
        begin
            queue_item(MODE_LOAD, i, (i % 2 == 0) ? 16'sh8000 : pick_value());
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_taps(phase_cfg[p]);
            if (p == 2)
            begin
                hold_requests++;
            end
            if (p == PHASES - 1)
            begin
                idle_on = 1'b0;
            end
            if (p == 4)
            begin
                queue_random(PHASE_BEATS / 2, phase_cfg[p]);
                settle();
                queue_random(PHASE_BEATS - PHASE_BEATS / 2, phase_cfg[p]);
            end
            else
            begin
                queue_random(PHASE_BEATS, phase_cfg[p]);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (filtered_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d outputs never arrived", filtered_q.size()));
        end

        $display("Covered %0d pushes, %0d coefficient loads, %0d restarts, %0d unused-mode beats",
                 n_push, n_load, n_restart, n_unused);
        $display("across %0d tap settings; %0d outputs checked, %0d mismatches",
                 n_settings, n_checked, errors);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/fvw_pkg.sv
rtl/core/fvw_mac.sv
rtl/core/fir_filter_valid_window.sv
tb/sv/fir_filter_valid_window_test.sv
